[src/nearest_neighbor_search_defines.svh]
// Assertion macros shared by the nearest neighbor search RTL
`ifndef NEAREST_NEIGHBOR_SEARCH_DEFINES_SVH
`define NEAREST_NEIGHBOR_SEARCH_DEFINES_SVH

`ifndef SYNTH
`define NNS_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("nns: same-cycle check failed");
`define NNS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("nns: next-cycle check failed");
`else
`define NNS_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define NNS_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

[src/nns_pkg.sv]
// Types and constants of the nearest neighbor search block
package nns_pkg;

  localparam int unsigned VALUE_BITS    = 16;
  localparam int unsigned ENTRY_BITS    = 8;
  localparam int unsigned COMP_BITS     = 6;
  localparam int unsigned LABEL_BITS    = 8;
  localparam int unsigned DIST_BITS     = 48;
  localparam int unsigned COUNT_BITS    = 9;
  localparam int unsigned ENTRY_LIMIT   = 256;
  localparam int unsigned APB_ADDR_BITS = 3;
  localparam int unsigned APB_DATA_BITS = 32;

  localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic                         operation;
    logic [ENTRY_BITS-1:0]        entry_index;
    logic [COMP_BITS-1:0]         component_index;
    logic signed [VALUE_BITS-1:0] component_value;
    logic [LABEL_BITS-1:0]        class_label;
    logic                         last_component;
  } req_t;

  typedef struct packed {
    logic [ENTRY_BITS-1:0] best_entry;
    logic [LABEL_BITS-1:0] best_label;
    logic [DIST_BITS-1:0]  best_distance_sq;
    logic                  table_empty;
  } res_t;

  typedef enum logic {
    CMD_LOAD,
    CMD_QUERY
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                    kind;
    logic                         in_range;
    logic [ENTRY_BITS-1:0]        entry_index;
    logic [COMP_BITS-1:0]         component_index;
    logic signed [VALUE_BITS-1:0] component_value;
    logic [LABEL_BITS-1:0]        class_label;
    logic                         last_component;
  } cmd_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SWEEP,
    B_DRAIN,
    B_LABEL,
    B_EMIT
  } back_state_t;

endpackage

[src/nns_if.sv]
// Request and result channel interfaces
interface nns_req_if;
  logic          valid;
  logic          ready;
  nns_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface nns_res_if;
  logic          valid;
  logic          ready;
  nns_pkg::res_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[src/nns_ram.sv]
// Generic single-write, single-read RAM with registered read data
module nns_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

[src/nns_fifo.sv]
// Short command queue between front and back
`include "nearest_neighbor_search_defines.svh"

module nns_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  nns_pkg::cmd_t din,
  output logic          full,
  input  logic          pop,
  output nns_pkg::cmd_t dout,
  output logic          empty
);
  import nns_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cmd_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (!push && pop) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  `NNS_ASSERT_IMPL(a_no_push_full, clk, rst, push, !full)
  `NNS_ASSERT_IMPL(a_no_pop_empty, clk, rst, pop, !empty)
  `NNS_ASSERT_IMPL(a_count_bound, clk, rst, 1'b1, count <= CW'(DEPTH))
endmodule

[src/nns_front.sv]
// Front end: accept requests, classify them and range-check indexes
module nns_front #(
  parameter int unsigned NUM_ENTRIES = 256,
  parameter int unsigned MAX_DIMS    = 64
) (
  nns_req_if.sink       req,
  input  logic          full,
  output logic          push,
  output nns_pkg::cmd_t cmd
);
  import nns_pkg::*;

  logic entry_ok;
  logic comp_ok;

  assign entry_ok  = (32'(req.data.entry_index) < NUM_ENTRIES);
  assign comp_ok   = (32'(req.data.component_index) < MAX_DIMS);
  assign req.ready = !full;
  assign push      = req.valid && !full;

  always_comb begin
    cmd.kind            = (req.data.operation == OP_QUERY) ? CMD_QUERY : CMD_LOAD;
    cmd.in_range        = (req.data.operation == OP_QUERY) ? comp_ok : (comp_ok && entry_ok);
    cmd.entry_index     = req.data.entry_index;
    cmd.component_index = req.data.component_index;
    cmd.component_value = req.data.component_value;
    cmd.class_label     = req.data.class_label;
    cmd.last_component  = req.data.last_component;
  end
endmodule

[src/nns_back.sv]
// Back end: store loads, sweep accumulators per query component, emit the nearest entry
`include "nearest_neighbor_search_defines.svh"

module nns_back #(
  parameter int unsigned NUM_ENTRIES = 256,
  parameter int unsigned MAX_DIMS    = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  nns_pkg::cmd_t                    cmd,
  input  logic                             empty,
  output logic                             pop,
  input  logic [nns_pkg::COUNT_BITS-1:0]   entries_in_use,
  nns_res_if.source                        res
);
  import nns_pkg::*;

  localparam int unsigned EW  = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int unsigned RD  = NUM_ENTRIES * MAX_DIMS;
  localparam int unsigned AW  = (RD > 1) ? $clog2(RD) : 1;
  localparam int unsigned CW  = $clog2(NUM_ENTRIES + 1);
  localparam int unsigned DFW = VALUE_BITS + 1;
  localparam int unsigned SQW = 2 * DFW;

  back_state_t state;
  back_state_t state_next;

  logic issue;
  logic res_load;
  logic start_q;
  logic ld_en;

  logic [CW-1:0] cnt;
  logic [AW-1:0] ld_addr;

  logic                         query_open;
  logic                         q_comp_ok;
  logic                         q_last;
  logic                         q_empty;
  logic signed [VALUE_BITS-1:0] q_value;
  logic [EW-1:0]                last_e;
  logic [EW-1:0]                e_a;
  logic [AW-1:0]                ref_addr;

  logic [NUM_ENTRIES-1:0] vld;
  logic                   vb;
  logic [EW-1:0]          e_b;
  logic                   vc;
  logic [EW-1:0]          e_c;
  logic [SQW-1:0]         sq_c;
  logic [DIST_BITS-1:0]   acc_c;

  logic [DIST_BITS-1:0] best_dist;
  logic [EW-1:0]        best_idx;

  logic [VALUE_BITS-1:0] ref_rdata;
  logic [DIST_BITS-1:0]  acc_rdata;
  logic [LABEL_BITS-1:0] label_rdata;

  logic signed [DFW-1:0] diff;
  logic [DFW-1:0]        mag;
  logic [SQW-1:0]        sq;
  logic [DIST_BITS-1:0]  acc_g;
  logic [DIST_BITS:0]    sum;
  logic [DIST_BITS-1:0]  acc_new;

  assign cnt = (32'(entries_in_use) > NUM_ENTRIES) ? CW'(NUM_ENTRIES) : CW'(entries_in_use);
  assign ld_addr = AW'(32'(cmd.entry_index) * MAX_DIMS + 32'(cmd.component_index));
  assign start_q = pop && (cmd.kind == CMD_QUERY);
  assign ld_en   = pop && (cmd.kind == CMD_LOAD) && cmd.in_range;

  assign diff    = {q_value[VALUE_BITS-1], q_value} -
                   {ref_rdata[VALUE_BITS-1], ref_rdata};
  assign mag     = diff[DFW-1] ? DFW'(-diff) : DFW'(diff);
  assign sq      = mag * mag;
  assign acc_g   = vld[e_b] ? acc_rdata : '0;
  assign sum     = {1'b0, acc_c} + (DIST_BITS + 1)'(sq_c);
  assign acc_new = (sum >= {1'b0, DIST_MAX}) ? DIST_MAX : sum[DIST_BITS-1:0];

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (!empty && (cmd.kind == CMD_QUERY)) begin
          if (cnt != '0) begin
            state_next = B_SWEEP;
          end else if (cmd.last_component) begin
            state_next = B_EMIT;
          end
        end
      end
      B_SWEEP: begin
        if (e_a == last_e) begin
          state_next = B_DRAIN;
        end
      end
      B_DRAIN: begin
        if (!vb && !vc) begin
          state_next = q_last ? B_LABEL : B_IDLE;
        end
      end
      B_LABEL: begin
        state_next = B_EMIT;
      end
      B_EMIT: begin
        if (!res.valid || res.ready) begin
          state_next = B_IDLE;
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    issue    = 1'b0;
    res_load = 1'b0;
    unique case (state)
      B_IDLE:  pop      = !empty;
      B_SWEEP: issue    = 1'b1;
      B_EMIT:  res_load = !res.valid || res.ready;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_IDLE;
      query_open <= 1'b0;
      vld        <= '0;
      vb         <= 1'b0;
      vc         <= 1'b0;
      res.valid  <= 1'b0;
    end else begin
      state <= state_next;
      vb    <= issue;
      vc    <= vb;
      if (start_q) begin
        query_open <= !cmd.last_component;
        // drop the previous query's sums
        if (!query_open) begin
          vld <= '0;
        end
      end
      if (vc) begin
        vld[e_c] <= 1'b1;
      end
      if (res_load) begin
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_q) begin
      q_comp_ok <= cmd.in_range;
      q_last    <= cmd.last_component;
      q_empty   <= (cnt == '0);
      q_value   <= cmd.component_value;
      last_e    <= EW'(cnt - 1'b1);
      e_a       <= '0;
      ref_addr  <= AW'(cmd.component_index);
    end else if (issue) begin
      e_a      <= e_a + 1'b1;
      ref_addr <= ref_addr + AW'(MAX_DIMS);
    end
    e_b   <= e_a;
    e_c   <= e_b;
    sq_c  <= q_comp_ok ? sq : '0;
    acc_c <= acc_g;
    // keep the first entry on a tie
    if (vc && ((e_c == '0) || (acc_new < best_dist))) begin
      best_dist <= acc_new;
      best_idx  <= e_c;
    end
    if (res_load) begin
      res.data.table_empty      <= q_empty;
      res.data.best_entry       <= q_empty ? '0 : ENTRY_BITS'(best_idx);
      res.data.best_label       <= q_empty ? '0 : label_rdata;
      res.data.best_distance_sq <= q_empty ? '0 : best_dist;
    end
  end

  nns_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (RD)
  ) u_ref_ram (
    .clk     (clk),
    .wr_en   (ld_en),
    .wr_addr (ld_addr),
    .wr_data (cmd.component_value),
    .rd_addr (ref_addr),
    .rd_data (ref_rdata)
  );

  nns_ram #(
    .WIDTH (LABEL_BITS),
    .DEPTH (NUM_ENTRIES)
  ) u_label_ram (
    .clk     (clk),
    .wr_en   (ld_en),
    .wr_addr (EW'(cmd.entry_index)),
    .wr_data (cmd.class_label),
    .rd_addr (best_idx),
    .rd_data (label_rdata)
  );

  nns_ram #(
    .WIDTH (DIST_BITS),
    .DEPTH (NUM_ENTRIES)
  ) u_acc_ram (
    .clk     (clk),
    .wr_en   (vc),
    .wr_addr (e_c),
    .wr_data (acc_new),
    .rd_addr (e_a),
    .rd_data (acc_rdata)
  );

  `NNS_ASSERT_IMPL(a_label_drained, clk, rst, state == B_LABEL, !vb && !vc)
  `NNS_ASSERT_IMPL(a_sweep_bound, clk, rst, state == B_SWEEP, e_a <= last_e)
  `NNS_ASSERT_NEXT(a_emit_loads, clk, rst, res_load, res.valid)
endmodule

[src/nearest_neighbor_search.sv]
// Top level of the nearest neighbor search block: APB register, front, queue, back
// A load request is written in the idle state. A query component sweeps the accumulators
// of min(entries_in_use, NUM_ENTRIES) entries, one entry per cycle, then drains.
// The last component adds a label fetch; its result is registered.
// A queue of four requests lets the front accept while the back sweeps.
// rst (synchronous) clears control, entries_in_use and the accumulator valid bits;
// the reference and label stores are undefined until written and get no clearing pass.
module nearest_neighbor_search #(
  parameter int unsigned MAX_ENTRIES = 256,
  parameter int unsigned MAX_DIMS    = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  nns_req_if.sink                             req,
  nns_res_if.source                           res,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [nns_pkg::APB_ADDR_BITS-1:0]   paddr,
  input  logic [nns_pkg::APB_DATA_BITS-1:0]   pwdata,
  output logic [nns_pkg::APB_DATA_BITS-1:0]   prdata,
  output logic                                pready
);
  import nns_pkg::*;

  localparam int unsigned NUM_ENTRIES = (MAX_ENTRIES < ENTRY_LIMIT) ? MAX_ENTRIES : ENTRY_LIMIT;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam logic        REG_ENTRIES_IN_USE = 1'b0;

  logic [COUNT_BITS-1:0] entries_in_use;
  logic                  push;
  logic                  pop;
  logic                  full;
  logic                  empty;
  cmd_t                  cmd_in;
  cmd_t                  cmd_out;

  assign pready = 1'b1;
  assign prdata = (paddr[APB_ADDR_BITS-1] == REG_ENTRIES_IN_USE) ?
                  APB_DATA_BITS'(entries_in_use) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use <= '0;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[APB_ADDR_BITS-1] == REG_ENTRIES_IN_USE)) begin
      entries_in_use <= pwdata[COUNT_BITS-1:0];
    end
  end

  nns_front #(
    .NUM_ENTRIES (NUM_ENTRIES),
    .MAX_DIMS    (MAX_DIMS)
  ) u_front (
    .req  (req),
    .full (full),
    .push (push),
    .cmd  (cmd_in)
  );

  nns_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (cmd_in),
    .full  (full),
    .pop   (pop),
    .dout  (cmd_out),
    .empty (empty)
  );

  nns_back #(
    .NUM_ENTRIES (NUM_ENTRIES),
    .MAX_DIMS    (MAX_DIMS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd_out),
    .empty          (empty),
    .pop            (pop),
    .entries_in_use (entries_in_use),
    .res            (res)
  );
endmodule

[tb/tb_top.sv]
// Self-checking testbench for nearest_neighbor_search: table loads, queries, table size settings
`timescale 1ns / 100ps

module tb_top;
  import nns_pkg::*;

  localparam int unsigned DIMS = 1 << COMP_BITS;
  localparam int unsigned REG_ENTRIES_IN_USE = 0;
  localparam logic [APB_ADDR_BITS-1:0] ENTRIES_IN_USE_ADDR =
    APB_ADDR_BITS'(4 * REG_ENTRIES_IN_USE);
  localparam int unsigned TOTAL_ITEMS = 1950;
  localparam int unsigned QUIET_TAIL = 150;
  localparam longint unsigned TIMEOUT_NS = 64'd18_000_000;
  localparam res_t EMPTY_TABLE = '{best_entry: '0, best_label: '0, best_distance_sq: '0,
                                   table_empty: 1'b1};

  typedef struct packed {
    logic                  is_config;
    logic [COUNT_BITS-1:0] setting;
    req_t                  item;
    logic                  typed;
    res_t                  typed_result;
  } step_t;

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_BITS-1:0] paddr;
  logic [APB_DATA_BITS-1:0] pwdata;
  logic [APB_DATA_BITS-1:0] prdata;
  logic pready;
  logic result_ready = 1'b0;
  int unsigned hold_off = 0;

  nns_req_if request_ch ();
  nns_res_if result_ch ();

  assign result_ch.ready = result_ready;

  nearest_neighbor_search dut (
    .clk     (clk),
    .rst     (rst),
    .req     (request_ch),
    .res     (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  logic signed [VALUE_BITS-1:0] stored_vectors [ENTRY_LIMIT][DIMS];
  logic [LABEL_BITS-1:0] stored_labels [ENTRY_LIMIT];
  logic [DIST_BITS-1:0] running_dist [ENTRY_LIMIT];
  bit loaded_cells [ENTRY_LIMIT][DIMS];
  bit query_in_progress = 1'b0;
  logic [COUNT_BITS-1:0] entries_setting = '0;
  res_t pending_results [$];
  step_t directed_steps [$];

  int unsigned requests_accepted = 0;
  int unsigned loads_sent = 0;
  int unsigned queries_sent = 0;
  int unsigned settings_written = 0;
  int unsigned register_errors = 0;
  int unsigned results_seen = 0;
  int unsigned result_errors = 0;
  bit send_gaps_on = 1'b1;
  bit stalls_on = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned active_entries();
    return (entries_setting > ENTRY_LIMIT) ? ENTRY_LIMIT : int'(entries_setting);
  endfunction

  function automatic int unsigned sweep_drain_cycles();
    return (active_entries() + 4) * 6 + 8;
  endfunction

  function automatic void queue_expected(res_t r);
    pending_results.insert(pending_results.size(), r);
  endfunction

  function automatic logic signed [VALUE_BITS-1:0] pick_value();
    case ($urandom_range(0, 5))
      0: return {1'b0, {(VALUE_BITS - 1){1'b1}}};
      1: return {1'b1, {(VALUE_BITS - 1){1'b0}}};
      2, 3: return VALUE_BITS'(int'($urandom_range(0, 6)) - 3);
      default: return VALUE_BITS'($urandom);
    endcase
  endfunction

  function automatic req_t make_load(logic [ENTRY_BITS-1:0] entry, logic [COMP_BITS-1:0] comp,
                                     logic signed [VALUE_BITS-1:0] value,
                                     logic [LABEL_BITS-1:0] label);
    req_t r;
    r.operation = OP_LOAD;
    r.entry_index = entry;
    r.component_index = comp;
    r.component_value = value;
    r.class_label = label;
    r.last_component = 1'($urandom);
    return r;
  endfunction

  function automatic req_t make_query(logic [COMP_BITS-1:0] comp,
                                      logic signed [VALUE_BITS-1:0] value, logic last);
    req_t r;
    r.operation = OP_QUERY;
    r.entry_index = ENTRY_BITS'($urandom);
    r.component_index = comp;
    r.component_value = value;
    r.class_label = LABEL_BITS'($urandom);
    r.last_component = last;
    return r;
  endfunction

  function automatic req_t scattered_load(int unsigned active, logic [COMP_BITS-1:0] hint);
    int unsigned entry;
    logic [COMP_BITS-1:0] comp;
    entry = (active != 0 && $urandom_range(0, 3) != 0) ? $urandom_range(0, active - 1)
                                                       : $urandom_range(0, ENTRY_LIMIT - 1);
    comp = ($urandom_range(0, 2) != 0) ? hint : COMP_BITS'($urandom_range(0, DIMS - 1));
    return make_load(ENTRY_BITS'(entry), comp, pick_value(), LABEL_BITS'($urandom));
  endfunction

  function automatic res_t exact_match(logic [ENTRY_BITS-1:0] entry,
                                       logic [LABEL_BITS-1:0] label);
    res_t r;
    r = '0;
    r.best_entry = entry;
    r.best_label = label;
    return r;
  endfunction

  function automatic step_t request_step(req_t item);
    step_t s;
    s = '0;
    s.item = item;
    return s;
  endfunction

  function automatic step_t typed_step(req_t item, res_t result);
    step_t s;
    s = '0;
    s.item = item;
    s.typed = 1'b1;
    s.typed_result = result;
    return s;
  endfunction

  function automatic step_t config_step(logic [COUNT_BITS-1:0] setting);
    step_t s;
    s = '0;
    s.is_config = 1'b1;
    s.setting = setting;
    return s;
  endfunction

  task automatic advance_search(input req_t item, output bit produced, output res_t outcome);
    int unsigned active;
    int unsigned best;
    longint diff;
    logic [DIST_BITS:0] sum;
    logic [DIST_BITS-1:0] best_dist;
    produced = 1'b0;
    outcome = '0;
    if (item.operation == OP_LOAD) begin
      stored_vectors[item.entry_index][item.component_index] = item.component_value;
      stored_labels[item.entry_index] = item.class_label;
      loaded_cells[item.entry_index][item.component_index] = 1'b1;
      return;
    end
    active = active_entries();
    if (!query_in_progress) begin
      foreach (running_dist[e]) running_dist[e] = '0;
      query_in_progress = 1'b1;
    end
    for (int e = 0; e < active; e++) begin
      diff = longint'($signed(item.component_value)) -
             longint'($signed(stored_vectors[e][item.component_index]));
      sum = {1'b0, running_dist[e]} + (DIST_BITS + 1)'(diff * diff);
      running_dist[e] = (sum >= {1'b0, DIST_MAX}) ? DIST_MAX : sum[DIST_BITS-1:0];
    end
    if (!item.last_component) return;
    query_in_progress = 1'b0;
    produced = 1'b1;
    if (active == 0) begin
      outcome.table_empty = 1'b1;
      return;
    end
    best = 0;
    best_dist = running_dist[0];
    for (int e = 1; e < active; e++) begin
      if (running_dist[e] < best_dist) begin
        best_dist = running_dist[e];
        best = e;
      end
    end
    outcome.best_entry = ENTRY_BITS'(best);
    outcome.best_label = stored_labels[best];
    outcome.best_distance_sq = best_dist;
  endtask

  task automatic send_request(input req_t item, input bit typed, input res_t typed_result);
    bit produced;
    res_t outcome;
    if (send_gaps_on && requests_accepted + QUIET_TAIL < TOTAL_ITEMS &&
        $urandom_range(0, 4) == 0) begin
      request_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    request_ch.valid <= 1'b1;
    request_ch.data <= item;
    @(posedge clk);
    while (!request_ch.ready) @(posedge clk);
    requests_accepted++;
    if (item.operation == OP_LOAD) loads_sent++;
    else queries_sent++;
    advance_search(item, produced, outcome);
    if (produced) queue_expected(typed ? typed_result : outcome);
  endtask

  task automatic set_entries(input logic [COUNT_BITS-1:0] setting);
    request_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (sweep_drain_cycles()) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ENTRIES_IN_USE_ADDR;
    pwdata <= APB_DATA_BITS'(setting);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    entries_setting = setting;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[COUNT_BITS-1:0] !== setting) begin
      $error("entries_in_use: expected %0d, got %0d", setting, prdata[COUNT_BITS-1:0]);
      register_errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    settings_written++;
  endtask

  // hold the result side off in random bursts
  always @(posedge clk) begin
    if (hold_off != 0) begin
      hold_off <= hold_off - 1;
    end else if (stalls_on && requests_accepted + QUIET_TAIL < TOTAL_ITEMS &&
                 $urandom_range(0, 11) == 0) begin
      result_ready <= 1'b0;
      hold_off <= $urandom_range(0, 18);
    end else begin
      result_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : score_results
    res_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result with no query waiting: entry %0d", result_ch.data.best_entry);
        result_errors++;
      end else begin
        want = pending_results.pop_front();
        if (result_ch.data.best_entry !== want.best_entry) begin
          $error("best_entry: expected %0d, got %0d", want.best_entry,
                 result_ch.data.best_entry);
          result_errors++;
        end
        if (result_ch.data.best_label !== want.best_label) begin
          $error("best_label: expected %0d, got %0d", want.best_label,
                 result_ch.data.best_label);
          result_errors++;
        end
        if (result_ch.data.best_distance_sq !== want.best_distance_sq) begin
          $error("best_distance_sq: expected %0d, got %0d", want.best_distance_sq,
                 result_ch.data.best_distance_sq);
          result_errors++;
        end
        if (result_ch.data.table_empty !== want.table_empty) begin
          $error("table_empty: expected %0d, got %0d", want.table_empty,
                 result_ch.data.table_empty);
          result_errors++;
        end
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Verification failed");
    $finish;
  end

  initial begin
    int unsigned phase;
    int unsigned active;
    int unsigned n_dims;
    int unsigned phase_stop;
    int unsigned start;
    int unsigned len;
    bit found;
    logic [COMP_BITS-1:0] dims [3];
    logic [COUNT_BITS-1:0] setting;

    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    request_ch.valid <= 1'b0;
    request_ch.data <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed_steps = '{
      typed_step(make_query(6'd0, 16'sh0000, 1'b1), EMPTY_TABLE),
      request_step(make_query(6'd63, 16'sh8000, 1'b0)),
      typed_step(make_query(6'd63, 16'sh7fff, 1'b1), EMPTY_TABLE),
      request_step(make_load(8'd0, 6'd0, 16'sh7fff, 8'hff)),
      request_step(make_load(8'd1, 6'd0, 16'sh8000, 8'h00)),
      request_step(make_load(8'd2, 6'd0, 16'sh7fff, 8'h55)),
      request_step(make_load(8'd255, 6'd63, 16'sh5a5a, 8'haa)),
      config_step(9'd1),
      typed_step(make_query(6'd0, 16'sh7fff, 1'b1), exact_match(8'd0, 8'hff)),
      config_step(9'd3),
      typed_step(make_query(6'd0, 16'sh8000, 1'b1), exact_match(8'd1, 8'h00)),
      typed_step(make_query(6'd0, 16'sh7fff, 1'b1), exact_match(8'd0, 8'hff)),
      request_step(make_query(6'd0, 16'sh0000, 1'b0)),
      request_step(make_query(6'd0, 16'sh0000, 1'b1)),
      request_step(make_query(6'd0, 16'sh0000, 1'b0)),
      request_step(make_load(8'd1, 6'd0, 16'sh0000, 8'h11)),
      request_step(make_query(6'd0, 16'sh0000, 1'b1)),
      request_step(make_query(6'd0, 16'sh7fff, 1'b0)),
      request_step(make_query(6'd0, 16'sh7fff, 1'b1))
    };
    foreach (directed_steps[i]) begin
      if (directed_steps[i].is_config) set_entries(directed_steps[i].setting);
      else send_request(directed_steps[i].item, directed_steps[i].typed,
                        directed_steps[i].typed_result);
    end

    phase = 0;
    while (requests_accepted < TOTAL_ITEMS) begin
      case (phase)
        1: setting = '1;
        4: setting = COUNT_BITS'(ENTRY_LIMIT);
        7: setting = '0;
        default: setting = ($urandom_range(0, 11) == 0)
                           ? COUNT_BITS'($urandom_range(ENTRY_LIMIT + 1, 510))
                           : COUNT_BITS'($urandom_range(1, 24));
      endcase
      set_entries(setting);
      active = active_entries();
      send_gaps_on = $urandom_range(0, 3) != 0;
      stalls_on = $urandom_range(0, 3) != 0;

      if (active > 32) begin
        n_dims = 1;
        start = $urandom_range(0, DIMS - 1);
        dims[0] = COMP_BITS'(start);
        for (int k = 0; k < DIMS; k++) begin
          found = 1'b1;
          for (int e = 0; e < active; e++) begin
            if (!loaded_cells[e][(start + k) % DIMS]) found = 1'b0;
          end
          if (found) begin
            dims[0] = COMP_BITS'((start + k) % DIMS);
            break;
          end
        end
      end else begin
        n_dims = $urandom_range(1, 3);
        for (int d = 0; d < 3; d++) begin
          dims[d] = ($urandom_range(0, 3) == 0) ? '1 : COMP_BITS'($urandom_range(0, DIMS - 1));
        end
      end

      // fill every searched entry at the query columns
      for (int e = 0; e < active; e++) begin
        for (int d = 0; d < n_dims; d++) begin
          if (!loaded_cells[e][dims[d]] || $urandom_range(0, 3) == 0) begin
            send_request(make_load(ENTRY_BITS'(e), dims[d], pick_value(),
                                   LABEL_BITS'($urandom)), 1'b0, '0);
          end
        end
      end

      phase_stop = requests_accepted + $urandom_range(80, 140);
      if (phase_stop > TOTAL_ITEMS) phase_stop = TOTAL_ITEMS;
      while (requests_accepted < phase_stop) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: begin
            len = $urandom_range(1, 6);
            for (int k = 0; k < len; k++) begin
              if ($urandom_range(0, 7) == 0) begin
                send_request(scattered_load(active, dims[$urandom_range(0, n_dims - 1)]),
                             1'b0, '0);
              end
              send_request(make_query(dims[$urandom_range(0, n_dims - 1)], pick_value(),
                                      k == len - 1), 1'b0, '0);
            end
          end
          6, 7, 8: send_request(scattered_load(active, dims[$urandom_range(0, n_dims - 1)]),
                                1'b0, '0);
          default: send_request(make_query(dims[$urandom_range(0, n_dims - 1)], pick_value(),
                                           1'($urandom)), 1'b0, '0);
        endcase
      end
      // close an open query before the next table size
      if (query_in_progress) begin
        send_request(make_query(dims[0], pick_value(), 1'b1), 1'b0, '0);
      end
      phase++;
    end

    request_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (sweep_drain_cycles()) @(posedge clk);

    $display("Sent %0d requests: %0d reference loads and %0d query components",
             requests_accepted, loads_sent, queries_sent);
    $display("Checked %0d search results over %0d table size settings",
             results_seen, settings_written);
    if (result_errors == 0 && register_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+src
src/nns_pkg.sv
src/nns_if.sv
src/nns_ram.sv
src/nns_fifo.sv
src/nns_front.sv
src/nns_back.sv
src/nearest_neighbor_search.sv
tb/tb_top.sv
